>>> rtl/msc_pkg.sv
// Package with shared types, constants and the band threshold table of the settings codec.
package msc_pkg;

    localparam logic [2:0] ATTR_OFFSET = 3'd0;
    localparam logic [2:0] ATTR_FREQ   = 3'd1;
    localparam logic [2:0] ATTR_GAIN   = 3'd2;
    localparam logic [2:0] ATTR_RATIO  = 3'd3;
    localparam logic [2:0] ATTR_PHASE  = 3'd4;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    localparam int NUM_REGS = 6;
    localparam int BAND_COUNT = 120;

    localparam logic [7:0] RESET_REG0 = 8'h2E;
    localparam logic [7:0] RESET_REG1 = 8'h84;
    localparam logic [7:0] RESET_REG2 = 8'h80;
    localparam logic [7:0] RESET_REG3 = 8'h80;
    localparam logic [7:0] RESET_REG4 = 8'h80;
    localparam logic [7:0] RESET_REG5 = 8'h10;

    localparam logic signed [63:0] POLY_C3 = -64'sd553;
    localparam logic signed [63:0] POLY_C2 = 64'sd198810;
    localparam logic signed [63:0] POLY_C1 = -64'sd26120002;
    localparam logic signed [63:0] POLY_C0 = 64'sd1319492809;

    localparam logic [20:0] KHZ_DIV = 21'd1000;

    typedef logic [2:0] reg_addr_t;

    function automatic logic [20:0] band_limit(input logic [6:0] idx);
        logic [20:0] lim;
        case (idx)
            7'd0: lim = 21'd1249100;   7'd1: lim = 21'd1248600;   7'd2: lim = 21'd1238100;
            7'd3: lim = 21'd1214100;   7'd4: lim = 21'd1191200;   7'd5: lim = 21'd1165600;
            7'd6: lim = 21'd1141000;   7'd7: lim = 21'd1120600;   7'd8: lim = 21'd1100500;
            7'd9: lim = 21'd1069500;   7'd10: lim = 21'd1039599;  7'd11: lim = 21'd1023100;
            7'd12: lim = 21'd1007100;  7'd13: lim = 21'd988300;   7'd14: lim = 21'd961800;
            7'd15: lim = 21'd941300;   7'd16: lim = 21'd921500;   7'd17: lim = 21'd895200;
            7'd18: lim = 21'd877600;   7'd19: lim = 21'd863600;   7'd20: lim = 21'd843200;
            7'd21: lim = 21'd826900;   7'd22: lim = 21'd807000;   7'd23: lim = 21'd792300;
            7'd24: lim = 21'd772200;   7'd25: lim = 21'd752700;   7'd26: lim = 21'd734000;
            7'd27: lim = 21'd724200;   7'd28: lim = 21'd704600;   7'd29: lim = 21'd688700;
            7'd30: lim = 21'd673200;   7'd31: lim = 21'd655200;   7'd32: lim = 21'd638100;
            7'd33: lim = 21'd624600;   7'd34: lim = 21'd611900;   7'd35: lim = 21'd598400;
            7'd36: lim = 21'd585100;   7'd37: lim = 21'd573900;   7'd38: lim = 21'd563100;
            7'd39: lim = 21'd548100;   7'd40: lim = 21'd538100;   7'd41: lim = 21'd529100;
            7'd42: lim = 21'd518500;   7'd43: lim = 21'd507000;   7'd44: lim = 21'd497700;
            7'd45: lim = 21'd488000;   7'd46: lim = 21'd471500;   7'd47: lim = 21'd457700;
            7'd48: lim = 21'd448700;   7'd49: lim = 21'd437400;   7'd50: lim = 21'd426600;
            7'd51: lim = 21'd417500;   7'd52: lim = 21'd407500;   7'd53: lim = 21'd398000;
            7'd54: lim = 21'd390100;   7'd55: lim = 21'd382800;   7'd56: lim = 21'd376600;
            7'd57: lim = 21'd369800;   7'd58: lim = 21'd353100;   7'd59: lim = 21'd339000;
            7'd60: lim = 21'd332600;   7'd61: lim = 21'd327200;   7'd62: lim = 21'd320600;
            7'd63: lim = 21'd313700;   7'd64: lim = 21'd309100;   7'd65: lim = 21'd304500;
            7'd66: lim = 21'd288100;   7'd67: lim = 21'd278300;   7'd68: lim = 21'd274200;
            7'd69: lim = 21'd270300;   7'd70: lim = 21'd266000;   7'd71: lim = 21'd261899;
            7'd72: lim = 21'd258200;   7'd73: lim = 21'd254100;   7'd74: lim = 21'd243600;
            7'd75: lim = 21'd233800;   7'd76: lim = 21'd230800;   7'd77: lim = 21'd228000;
            7'd78: lim = 21'd220200;   7'd79: lim = 21'd212600;   7'd80: lim = 21'd210000;
            7'd81: lim = 21'd207600;   7'd82: lim = 21'd202100;   7'd83: lim = 21'd196200;
            7'd84: lim = 21'd193700;   7'd85: lim = 21'd191200;   7'd86: lim = 21'd186600;
            7'd87: lim = 21'd182000;   7'd88: lim = 21'd179400;   7'd89: lim = 21'd176000;
            7'd90: lim = 21'd170100;   7'd91: lim = 21'd165000;   7'd92: lim = 21'd162500;
            7'd93: lim = 21'd160000;   7'd94: lim = 21'd156700;   7'd95: lim = 21'd153600;
            7'd96: lim = 21'd151100;   7'd97: lim = 21'd148600;   7'd98: lim = 21'd142500;
            7'd99: lim = 21'd139600;   7'd100: lim = 21'd136500;  7'd101: lim = 21'd134300;
            7'd102: lim = 21'd131200;  7'd103: lim = 21'd128100;  7'd104: lim = 21'd126000;
            7'd105: lim = 21'd123800;  7'd106: lim = 21'd121300;  7'd107: lim = 21'd118300;
            7'd108: lim = 21'd115700;  7'd109: lim = 21'd113500;  7'd110: lim = 21'd111300;
            7'd111: lim = 21'd109500;  7'd112: lim = 21'd107600;  7'd113: lim = 21'd105600;
            7'd114: lim = 21'd103000;  7'd115: lim = 21'd100300;  7'd116: lim = 21'd98500;
            7'd117: lim = 21'd96600;   7'd118: lim = 21'd94700;   7'd119: lim = 21'd93000;
            default: lim = 21'd0;
        endcase
        return lim;
    endfunction

endpackage

>>> rtl/modulator_settings_codec.sv
// Top level of the quadrature modulator settings codec.
//
//  channel  | direction | handshake        | payload
//  request  | in        | in_valid/in_stall   | req_type, attribute, channel, value
//  result   | out       | out_valid/out_stall | status, read_value, frame_*, last
//
// A frequency read steps the cubic in Horner form modulo 2^32 on one shared 32x7
// multiplier; a phase write gives two results, the second one for register 0.
// A frequency write walks the band table with one shared compare, one threshold per cycle,
// testing the value against each threshold scaled to hertz until a hit or the table's end.
// Reset loads the register image with its defaults at once.
// The request side is stalled until the last result of a request has been taken,
// so a stall on the result side also holds off the next request.
module modulator_settings_codec
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [2:0]  attribute,
    input  logic        channel,
    input  logic signed [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic signed [31:0] read_value,
    output logic        frame_valid,
    output logic [7:0]  frame_cmd,
    output logic [7:0]  frame_data,
    output logic        last
);
    import msc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_DEC   = 7'b000_0010,
        ST_BAND  = 7'b000_0100,
        ST_MUL   = 7'b000_1000,
        ST_ADD   = 7'b001_0000,
        ST_OUT   = 7'b010_0000,
        ST_OUT2  = 7'b100_0000
    } state_t;

    state_t state_reg, state_next;
    logic [7:0] img_reg [NUM_REGS];
    logic        rd_reg;
    logic [2:0]  attr_reg;
    logic        ch_reg;
    logic signed [31:0] val_reg;
    logic [6:0]  idx_reg;
    logic [1:0]  step_reg;
    logic [31:0] acc_reg;
    logic        o_status_reg, o_fv_reg, o_last_reg;
    logic signed [31:0] o_rv_reg;
    logic [7:0]  o_cmd_reg, o_data_reg;
    logic [7:0]  r0_pend_reg;

    logic signed [31:0] v;
    logic [6:0] t;
    logic [31:0] prod;
    logic [31:0] coef;
    logic [20:0] lim;
    logic [31:0] lim_hz;
    logic        band_hit;

    assign v = val_reg;
    assign t = img_reg[0][6:0];
    assign lim = band_limit(idx_reg);
    assign lim_hz = ({11'd0, lim} + 32'd1) * {11'd0, KHZ_DIV};
    assign band_hit = ($unsigned(v) >= lim_hz);
    assign prod = acc_reg * {25'd0, t};

    always_comb
    begin
        case (step_reg)
            2'd0: coef = POLY_C2[31:0];
            2'd1: coef = POLY_C1[31:0];
            default: coef = POLY_C0[31:0];
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT) || (state_reg == ST_OUT2);
    assign status = o_status_reg;
    assign read_value = o_rv_reg;
    assign frame_valid = o_fv_reg;
    assign frame_cmd = o_cmd_reg;
    assign frame_data = o_data_reg;
    assign last = o_last_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_DEC;
            ST_DEC: if (!rd_reg && attr_reg == ATTR_FREQ && v >= 30000000 && v <= 1300000000)
                    state_next = ST_BAND;
                else if (rd_reg && attr_reg == ATTR_FREQ)
                    state_next = ST_MUL;
                else
                    state_next = ST_OUT;
            ST_BAND: if (band_hit || idx_reg == 7'(BAND_COUNT - 1)) state_next = ST_OUT;
            ST_MUL: if (step_reg == 2'd2) state_next = ST_ADD;
            ST_ADD: state_next = ST_OUT;
            ST_OUT: if (!out_stall) state_next = o_last_reg ? ST_IDLE : ST_OUT2;
            ST_OUT2: if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            img_reg[0] <= RESET_REG0;
            img_reg[1] <= RESET_REG1;
            img_reg[2] <= RESET_REG2;
            img_reg[3] <= RESET_REG3;
            img_reg[4] <= RESET_REG4;
            img_reg[5] <= RESET_REG5;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && !out_stall && o_fv_reg)
                img_reg[o_cmd_reg[3:1]] <= o_data_reg;
            if (state_reg == ST_OUT2 && !out_stall)
                img_reg[o_cmd_reg[3:1]] <= o_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                rd_reg <= req_type;
                attr_reg <= attribute;
                ch_reg <= channel;
                val_reg <= value;
            end
            ST_DEC:
            begin
                o_status_reg <= STATUS_DONE;
                o_rv_reg <= '0;
                o_fv_reg <= 1'b0;
                o_cmd_reg <= '0;
                o_data_reg <= '0;
                o_last_reg <= 1'b1;
                idx_reg <= '0;
                step_reg <= '0;
                acc_reg <= POLY_C3[31:0];
                if (rd_reg == REQ_READ)
                begin
                    case (attr_reg)
                        ATTR_OFFSET: o_rv_reg <= 32'(img_reg[{2'd1, ch_reg}]) - 32'd128;
                        ATTR_FREQ: ;
                        ATTR_GAIN: o_rv_reg <= -32'(img_reg[1][4:0]);
                        ATTR_RATIO: o_rv_reg <= 32'(img_reg[4]) - 32'd128;
                        ATTR_PHASE: o_rv_reg <= 32'(img_reg[5][4:0]) - 32'd16
                            + (img_reg[0][7] ? 32'(img_reg[5][7:5]) << 5
                                             : -(32'(img_reg[5][7:5]) << 5));
                        default: o_status_reg <= STATUS_INVALID;
                    endcase
                end
                else
                begin
                    case (attr_reg)
                        ATTR_OFFSET:
                            if (v < -127 || v > 127) o_status_reg <= STATUS_INVALID;
                            else
                            begin
                                o_fv_reg <= 1'b1;
                                o_cmd_reg <= {4'd0, 2'd1, ch_reg, 1'b0};
                                o_data_reg <= v[7:0] + 8'd128;
                            end
                        ATTR_FREQ:
                            if (v < 30000000 || v > 1300000000) o_status_reg <= STATUS_INVALID;
                        ATTR_GAIN:
                            if (v > 0) o_status_reg <= STATUS_INVALID;
                            else
                            begin
                                o_fv_reg <= 1'b1;
                                o_cmd_reg <= 8'd2;
                                o_data_reg <= {img_reg[1][7:5],
                                    (v < -19) ? 5'd19 : 5'(-v)};
                            end
                        ATTR_RATIO:
                            if (v < -127 || v > 127) o_status_reg <= STATUS_INVALID;
                            else
                            begin
                                o_fv_reg <= 1'b1;
                                o_cmd_reg <= 8'd8;
                                o_data_reg <= v[7:0] ^ 8'h80;
                            end
                        ATTR_PHASE:
                            if (v < -240 || v > 239) o_status_reg <= STATUS_INVALID;
                            else
                            begin
                                o_fv_reg <= 1'b1;
                                o_last_reg <= 1'b0;
                                o_cmd_reg <= 8'd10;
                                o_data_reg <= {(v > 0) ? 3'(10'(v + 16) >> 5)
                                                       : 3'(10'(15 - v) >> 5),
                                               v[4:0] ^ 5'h10};
                                r0_pend_reg <= {(v >= -16), img_reg[0][6:0]};
                            end
                        default: o_status_reg <= STATUS_INVALID;
                    endcase
                end
            end
            ST_BAND:
            begin
                idx_reg <= idx_reg + 7'd1;
                if (band_hit || idx_reg == 7'(BAND_COUNT - 1))
                begin
                    o_fv_reg <= 1'b1;
                    o_cmd_reg <= 8'd0;
                    o_data_reg <= {img_reg[0][7],
                        band_hit ? idx_reg + 7'd1 : 7'(BAND_COUNT + 1)};
                end
            end
            ST_MUL:
            begin
                acc_reg <= prod + coef;
                step_reg <= step_reg + 2'd1;
            end
            ST_ADD: o_rv_reg <= acc_reg;
            ST_OUT:
                if (!out_stall && !o_last_reg)
                begin
                    o_cmd_reg <= 8'd0;
                    o_data_reg <= r0_pend_reg;
                    o_last_reg <= 1'b1;
                end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(in_valid && !in_stall))
        else $error("request accepted while a result is pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (last && !frame_valid))
        else $error("invalid result carries a frame");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_valid) |-> (frame_cmd[0] == 1'b0 && read_value == 0))
        else $error("frame result malformed");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
endmodule

>>> tb/tb_modulator_settings_codec.sv
// Testbench for the modulator settings codec with directed and random checked transfers.
`timescale 1ns / 100ps

module tb_modulator_settings_codec;
    import msc_pkg::*;

    typedef struct packed {
        logic              status;
        logic signed [31:0] read_value;
        logic              frame_valid;
        logic [7:0]        frame_cmd;
        logic [7:0]        frame_data;
        logic              last;
    } settings_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic req_type = 1'b0;
    logic [2:0] attribute = '0;
    logic channel = 1'b0;
    logic signed [31:0] value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic status;
    logic signed [31:0] read_value;
    logic frame_valid;
    logic [7:0] frame_cmd;
    logic [7:0] frame_data;
    logic last;

    settings_result_t expected_results[$];
    logic [7:0] reg_image[NUM_REGS];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    modulator_settings_codec i_dut (.*);

    always #2 clk = ~clk;

    function automatic logic [6:0] freq_to_band(input logic signed [31:0] hz);
        int unsigned khz;
        int unsigned limits[120];
        limits = '{1249100, 1248600, 1238100, 1214100, 1191200, 1165600, 1141000, 1120600,
            1100500, 1069500, 1039599, 1023100, 1007100, 988300, 961800, 941300, 921500,
            895200, 877600, 863600, 843200, 826900, 807000, 792300, 772200, 752700, 734000,
            724200, 704600, 688700, 673200, 655200, 638100, 624600, 611900, 598400, 585100,
            573900, 563100, 548100, 538100, 529100, 518500, 507000, 497700, 488000, 471500,
            457700, 448700, 437400, 426600, 417500, 407500, 398000, 390100, 382800, 376600,
            369800, 353100, 339000, 332600, 327200, 320600, 313700, 309100, 304500, 288100,
            278300, 274200, 270300, 266000, 261899, 258200, 254100, 243600, 233800, 230800,
            228000, 220200, 212600, 210000, 207600, 202100, 196200, 193700, 191200, 186600,
            182000, 179400, 176000, 170100, 165000, 162500, 160000, 156700, 153600, 151100,
            148600, 142500, 139600, 136500, 134300, 131200, 128100, 126000, 123800, 121300,
            118300, 115700, 113500, 111300, 109500, 107600, 105600, 103000, 100300, 98500,
            96600, 94700, 93000};
        khz = hz / 1000;
        for (int i = 0; i < 120; i++)
            if (khz > limits[i])
                return 7'(i + 1);
        return 7'd121;
    endfunction

    function automatic settings_result_t frame_result(input int addr, input logic [7:0] data,
                                                      input logic is_last);
        settings_result_t r;
        r = '0;
        r.frame_valid = 1'b1;
        r.frame_cmd = 8'(addr << 1);
        r.frame_data = data;
        r.last = is_last;
        reg_image[addr] = data;
        return r;
    endfunction

    task automatic predict_access(input logic rd, input logic [2:0] attr, input logic ch,
                                  input logic signed [31:0] v);
        settings_result_t r;
        longint t;
        longint acc;
        longint coarse;
        logic bad;
        logic [7:0] r0;
        r = '0;
        r.last = 1'b1;
        bad = 1'b0;
        if (rd == REQ_READ)
        begin
            case (attr)
                ATTR_OFFSET: r.read_value = 32'(int'(reg_image[2 + ch]) - 128);
                ATTR_FREQ:
                begin
                    t = reg_image[0][6:0];
                    acc = -553 * t * t * t + 198810 * t * t - 26120002 * t + 1319492809;
                    r.read_value = acc[31:0];
                end
                ATTR_GAIN: r.read_value = -32'(reg_image[1][4:0]);
                ATTR_RATIO: r.read_value = 32'(int'(reg_image[4]) - 128);
                ATTR_PHASE:
                begin
                    coarse = reg_image[5][7:5];
                    acc = longint'(reg_image[5][4:0]) - 16;
                    acc += reg_image[0][7] ? coarse * 32 : -coarse * 32;
                    r.read_value = acc[31:0];
                end
                default: r.status = STATUS_INVALID;
            endcase
            expected_results.push_back(r);
            return;
        end
        case (attr)
            ATTR_OFFSET: if (v < -127 || v > 127) bad = 1'b1;
                else expected_results.push_back(frame_result(2 + ch, 8'(v + 128), 1'b1));
            ATTR_FREQ: if (v < 30000000 || v > 1300000000) bad = 1'b1;
                else expected_results.push_back(frame_result(0,
                    {reg_image[0][7], freq_to_band(v)}, 1'b1));
            ATTR_GAIN: if (v > 0) bad = 1'b1;
                else expected_results.push_back(frame_result(1,
                    {reg_image[1][7:5], (v < -19) ? 5'd19 : 5'(-v)}, 1'b1));
            ATTR_RATIO: if (v < -127 || v > 127) bad = 1'b1;
                else expected_results.push_back(frame_result(4, v[7:0] ^ 8'h80, 1'b1));
            ATTR_PHASE: if (v < -240 || v > 239) bad = 1'b1;
                else
                begin
                    r0 = reg_image[0];
                    r0[7] = (v >= -16);
                    coarse = (v > 0) ? (v + 16) / 32 : (15 - v) / 32;
                    expected_results.push_back(frame_result(5,
                        {3'(coarse), v[4:0] ^ 5'h10}, 1'b0));
                    expected_results.push_back(frame_result(0, r0, 1'b1));
                end
            default: bad = 1'b1;
        endcase
        if (bad)
        begin
            r.status = STATUS_INVALID;
            expected_results.push_back(r);
        end
    endtask

    task automatic send_access(input logic rd, input logic [2:0] attr, input logic ch,
                               input logic signed [31:0] v);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rd;
        attribute <= attr;
        channel <= ch;
        value <= v;
        predict_access(rd, attr, ch, v);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        settings_result_t got;
        settings_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, read_value, frame_valid, frame_cmd, frame_data, last};
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: %p", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    function automatic logic signed [31:0] random_value(input logic [2:0] attr);
        case ($urandom_range(9))
            0: return $urandom;
            1: return -$urandom_range(300);
            default: ;
        endcase
        case (attr)
            ATTR_FREQ: return $urandom_range(1310000000, 25000000);
            ATTR_GAIN: return -$urandom_range(25);
            ATTR_PHASE: return $urandom_range(480) - 241;
            default: return $urandom_range(260) - 130;
        endcase
    endfunction

    task automatic run_directed_writes();
        send_access(REQ_WRITE, ATTR_OFFSET, 1'b0, -127);
        send_access(REQ_WRITE, ATTR_OFFSET, 1'b1, 127);
        send_access(REQ_WRITE, ATTR_OFFSET, 1'b0, 128);
        send_access(REQ_WRITE, ATTR_FREQ, 1'b0, 30000000);
        send_access(REQ_WRITE, ATTR_FREQ, 1'b0, 1300000000);
        send_access(REQ_WRITE, ATTR_FREQ, 1'b0, 93000999);
        send_access(REQ_WRITE, ATTR_FREQ, 1'b0, 29999999);
        send_access(REQ_WRITE, ATTR_GAIN, 1'b0, 32'sh8000_0000);
        send_access(REQ_WRITE, ATTR_GAIN, 1'b0, 1);
        send_access(REQ_WRITE, ATTR_RATIO, 1'b0, -128);
        send_access(REQ_WRITE, ATTR_PHASE, 1'b0, -240);
        send_access(REQ_WRITE, ATTR_PHASE, 1'b0, -17);
        send_access(REQ_WRITE, ATTR_PHASE, 1'b0, -16);
        send_access(REQ_WRITE, ATTR_PHASE, 1'b0, 239);
        send_access(REQ_WRITE, 3'd7, 1'b0, 32'sh7FFF_FFFF);
    endtask

    task automatic run_directed_reads();
        for (int a = 0; a < 8; a++)
            send_access(REQ_READ, 3'(a), a[0], 0);
        send_access(REQ_READ, ATTR_OFFSET, 1'b1, 0);
    endtask

    task automatic run_random_phase(input int count, input int idle, input int stall);
        logic [2:0] attr;
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            attr = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            send_access(1'($urandom_range(1)), attr, 1'($urandom_range(1)),
                        random_value(attr));
        end
    endtask

    initial
    begin
        reg_image = '{RESET_REG0, RESET_REG1, RESET_REG2, RESET_REG3, RESET_REG4, RESET_REG5};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed_reads();
        run_directed_writes();
        run_directed_reads();
        run_random_phase(330, 0, 0);
        run_random_phase(320, 78, 0);
        run_random_phase(320, 0, 78);
        run_random_phase(320, 12, 12);
        in_valid <= 1'b0;
        stall_pct = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule

>>> modulator_settings_codec.f
rtl/msc_pkg.sv
rtl/modulator_settings_codec.sv
tb/tb_modulator_settings_codec.sv
